@@ hdl/sba_pkg.sv @@
// Shared types and constants for the slab block allocator.
// No dependencies; imported by sba_div and slab_block_allocator.
`default_nettype none
package sba_pkg;

  localparam int unsigned DIV_W     = 21;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] REG_STRATEGY    = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [1:0] REG_SLAB_BYTES  = 2'd2;
  localparam logic [1:0] REG_GENERATION  = 2'd3;

  localparam logic [1:0] STRAT_BUMP = 2'd0;
  localparam logic [1:0] STRAT_LIST = 2'd1;
  localparam logic [1:0] STRAT_BINS = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUSH,
    ST_SCAN,
    ST_READ,
    ST_POP,
    ST_MUL,
    ST_BUMP,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_BIN,
    PH_MOD,
    PH_BLK
  } phase_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ hdl/slab_block_allocator.sv @@
// Slab block allocator: free lists in a link memory, bump pointer, counters.
// Depends on sba_pkg, sba_div and sba_link_mem.
// One request at a time. An allocate from a free list goes through the read,
// pop and multiply states, after a scan over empty bins in segregated mode
// (up to BINS), or goes through the bump state. A free runs the shared 21-bit
// divider once for the block number and, in segregated mode, once more for
// offset over stride; the stride and the modulo by BINS use constant
// reciprocal multiplies. The link memory read on a pop is registered. Results
// sit in an output register; a new request is taken while the last result is
// still waiting. Configuration is taken only between requests.
`default_nettype none
module slab_block_allocator #(
  parameter int unsigned BINS       = 8,
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [55:0]  s_axis_tdata,   // owner[31:0], free_offset[51:32]
  input  wire logic [0:0]   s_axis_tuser,   // op
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[0], block_offset[20:1], header_owner[52:21],
  // header_generation[84:53], bin_used[87:85], live_blocks[119:88]
  output      logic [119:0] m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [1:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_data_i
);
  import sba_pkg::*;

  localparam int unsigned BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned CNT_W = BIN_W + 1;
  localparam int unsigned IW    = $clog2(MAX_BLOCKS);
  localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(BINS - 1);
  localparam logic [CNT_W-1:0] LAST_SCAN = CNT_W'(BINS - 1);
  localparam int unsigned BIN_SH = $clog2(BINS);
  localparam int unsigned RCP_SH = 21 + BIN_SH;
  localparam logic [21:0] RCP_M  =
    22'(((64'd1 << RCP_SH) + 64'(BINS) - 64'd1) / 64'(BINS));

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  logic [1:0]  strategy_q;
  logic [15:0] bb_q;
  logic [20:0] slab_q;
  logic [31:0] gen_q;

  logic [IW-1:0]    bin_head_q [BINS];
  logic [BINS-1:0]  bin_valid_q, bin_valid_d;
  logic [IW-1:0]    list_head_q, list_head_d;
  logic             list_valid_q, list_valid_d;
  logic [BIN_W-1:0] start_bin_q, start_bin_d;
  logic [20:0]      bump_q, bump_d;
  logic [31:0]      alloc_q, alloc_d, live_q, live_d;

  logic             op_q, op_d;
  logic [31:0]      owner_q, owner_d;
  logic [19:0]      foff_q, foff_d;
  logic [BIN_W-1:0] bin_q, bin_d, bin_nxt;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IW-1:0]    blk_q, blk_d;
  logic [20:0]      tmp_q, tmp_d;
  logic             from_list_q, from_list_d;
  logic             ok_q, ok_d;
  logic [19:0]      off_q, off_d;
  logic [31:0]      prod;

  logic             head_we;
  logic [IW-1:0]    head_wdata;
  logic             m_valid_q, m_valid_d;
  logic [119:0]     m_data_q, m_data_d;

  logic             mem_we, mem_re;
  logic [IW:0]      mem_wdata, mem_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             s_fire, out_free, strat_bins;
  logic [21:0]      bump_sum;
  logic [5:0]       bin_ext;
  logic [42:0]      stride_prod, quot_prod;
  logic [20:0]      stride_w, quot_bins, mod_full;

  sba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sba_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (IW + 1)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (blk_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (blk_q),
    .rdata_o (mem_rdata)
  );

  assign s_fire      = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign strat_bins  = (strategy_q == STRAT_BINS);
  assign bin_nxt     = (bin_q == LAST_BIN) ? '0 : bin_q + 1'b1;
  assign bump_sum    = {1'b0, bump_q} + {6'b0, bb_q};
  assign prod        = 32'(blk_q) * 32'(bb_q);
  assign bin_ext     = 6'(bin_q);
  assign mem_wdata   = strat_bins ? {bin_valid_q[bin_q], bin_head_q[bin_q]}
                                  : {list_valid_q, list_head_q};
  assign stride_prod = 43'(slab_q) * 43'(RCP_M);
  assign stride_w    = 21'(stride_prod >> RCP_SH);
  assign quot_prod   = 43'(tmp_q) * 43'(RCP_M);
  assign quot_bins   = 21'(quot_prod >> RCP_SH);
  assign mod_full    = tmp_q - 21'(quot_bins * 21'(BINS));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser[0] == OP_FREE) begin
            state_d = (strategy_q != STRAT_BUMP && bb_q != '0) ? ST_DIV_GO : ST_DONE;
          end else if (strategy_q == STRAT_BINS) begin
            state_d = ST_SCAN;
          end else if (strategy_q != STRAT_BUMP && list_valid_q) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_BUMP;
          end
        end
      end
      ST_DIV_GO: begin
        if (ph_q != PH_MOD) begin
          state_d = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (ph_q == PH_BLK) begin
            state_d = (div_rsp.quo < 21'(MAX_BLOCKS)) ? ST_PUSH : ST_DONE;
          end else begin
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_PUSH: state_d = ST_DONE;
      ST_SCAN: begin
        if (bin_valid_q[bin_q]) begin
          state_d = ST_READ;
        end else if (cnt_q == LAST_SCAN) begin
          state_d = ST_BUMP;
        end
      end
      ST_READ: state_d = ST_POP;
      ST_POP:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DONE;
      ST_BUMP: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cfg_ready_o   = (state_q == ST_IDLE) && !s_axis_tvalid;
    mem_we        = (state_q == ST_PUSH);
    mem_re        = (state_q == ST_READ);
    div_req.start = (state_q == ST_DIV_GO) && (ph_q != PH_MOD);
    unique case (ph_q)
      PH_BIN: begin
        div_req.dividend = {1'b0, foff_q};
        div_req.divisor  = tmp_q;
      end
      PH_BLK: begin
        div_req.dividend = {1'b0, foff_q};
        div_req.divisor  = {5'b0, bb_q};
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase

    ph_d         = ph_q;
    op_d         = op_q;
    owner_d      = owner_q;
    foff_d       = foff_q;
    bin_d        = bin_q;
    cnt_d        = cnt_q;
    blk_d        = blk_q;
    tmp_d        = tmp_q;
    from_list_d  = from_list_q;
    ok_d         = ok_q;
    off_d        = off_q;
    bin_valid_d  = bin_valid_q;
    list_head_d  = list_head_q;
    list_valid_d = list_valid_q;
    start_bin_d  = start_bin_q;
    bump_d       = bump_q;
    alloc_d      = alloc_q;
    live_d       = live_q;
    head_we      = 1'b0;
    head_wdata   = blk_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          op_d        = s_axis_tuser[0];
          owner_d     = s_axis_tdata[31:0];
          foff_d      = s_axis_tdata[51:32];
          bin_d       = '0;
          ok_d        = 1'b0;
          off_d       = '0;
          from_list_d = 1'b0;
          cnt_d       = '0;
          blk_d       = list_head_q;
          tmp_d       = stride_w;
          ph_d        = (strat_bins && stride_w != '0) ? PH_BIN : PH_BLK;
          if (s_axis_tuser[0] == OP_ALLOC) begin
            if (strategy_q == STRAT_BINS) begin
              bin_d = start_bin_q;
            end else if (strategy_q != STRAT_BUMP && list_valid_q) begin
              from_list_d = 1'b1;
            end
          end
        end
      end
      ST_DIV_GO: begin
        if (ph_q == PH_MOD) begin
          bin_d = mod_full[BIN_W-1:0];
          ph_d  = PH_BLK;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          unique case (ph_q)
            PH_BIN: begin
              tmp_d = div_rsp.quo;
              ph_d  = PH_MOD;
            end
            PH_BLK: blk_d = div_rsp.quo[IW-1:0];
            default: ph_d = PH_BLK;
          endcase
        end
      end
      ST_PUSH: begin
        if (strat_bins) begin
          head_we             = 1'b1;
          bin_valid_d[bin_q]  = 1'b1;
        end else begin
          list_head_d  = blk_q;
          list_valid_d = 1'b1;
        end
      end
      ST_SCAN: begin
        if (bin_valid_q[bin_q]) begin
          blk_d       = bin_head_q[bin_q];
          start_bin_d = bin_nxt;
        end else begin
          bin_d = bin_nxt;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_POP: begin
        if (from_list_q) begin
          list_head_d  = mem_rdata[IW-1:0];
          list_valid_d = mem_rdata[IW];
        end else begin
          head_we            = 1'b1;
          head_wdata         = mem_rdata[IW-1:0];
          bin_valid_d[bin_q] = mem_rdata[IW];
        end
      end
      ST_MUL: begin
        ok_d  = 1'b1;
        off_d = prod[19:0];
      end
      ST_BUMP: begin
        bin_d = '0;
        if (bump_sum <= {1'b0, slab_q}) begin
          ok_d   = 1'b1;
          off_d  = bump_q[19:0];
          bump_d = bump_sum[20:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if (op_q == OP_FREE) begin
            live_d   = live_q - 1'b1;
            m_data_d = {live_q - 1'b1, bin_ext[2:0], 32'b0, 32'b0, 20'b0, 1'b0};
          end else if (ok_q) begin
            live_d   = live_q + 1'b1;
            alloc_d  = alloc_q + 1'b1;
            m_data_d = {live_q + 1'b1, bin_ext[2:0], gen_q, owner_q, off_q, 1'b0};
          end else begin
            m_data_d = {live_q, 3'b0, 32'b0, 32'b0, 20'b0, 1'b1};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ph_q         <= PH_BLK;
      strategy_q   <= STRAT_LIST;
      bb_q         <= 16'd64;
      slab_q       <= 21'd65536;
      gen_q        <= '0;
      bin_valid_q  <= '0;
      list_valid_q <= 1'b0;
      start_bin_q  <= '0;
      bump_q       <= '0;
      alloc_q      <= '0;
      live_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      ph_q         <= ph_d;
      bin_valid_q  <= bin_valid_d;
      list_valid_q <= list_valid_d;
      start_bin_q  <= start_bin_d;
      bump_q       <= bump_d;
      alloc_q      <= alloc_d;
      live_q       <= live_d;
      m_valid_q    <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_addr_i)
          REG_STRATEGY:    strategy_q <= cfg_data_i[1:0];
          REG_BLOCK_BYTES: bb_q       <= cfg_data_i[15:0];
          REG_SLAB_BYTES:  slab_q     <= cfg_data_i[20:0];
          REG_GENERATION:  gen_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    owner_q     <= owner_d;
    foff_q      <= foff_d;
    bin_q       <= bin_d;
    cnt_q       <= cnt_d;
    blk_q       <= blk_d;
    tmp_q       <= tmp_d;
    from_list_q <= from_list_d;
    ok_q        <= ok_d;
    off_q       <= off_d;
    list_head_q <= list_head_d;
    m_data_q    <= m_data_d;
    if (head_we) begin
      bin_head_q[bin_q] <= head_wdata;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_read_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> (state_q == ST_POP))
    else $error("link read not followed by pop");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside wait state");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
    else $error("result dropped while output stalled");

  a_push_only_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (op_q == OP_FREE && strategy_q != STRAT_BUMP))
    else $error("link write outside a free");

endmodule
`default_nettype wire

@@ hdl/sba_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sba_pkg for widths and request/response structs.
`default_nettype none
module sba_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sba_pkg::div_req_t req_i,
  output      sba_pkg::div_rsp_t rsp_o
);
  import sba_pkg::*;

  logic [DIV_W-1:0]     rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_W:0]       shifted, diff;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      dsr_d = req_i.divisor;
      cnt_d = DIV_CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = diff[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

@@ hdl/sba_link_mem.sv @@
// Block link memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module sba_link_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
